// ===== hw/rtl/llpr_pkg.sv =====
// Shared types, constants and the control program of the light level PI regulator.
// Used by the channel interfaces and by every module of the regulator; depends on nothing.
package llpr_pkg;

   // Payload widths.
   localparam int RawWidth     = 16;
   localparam int CountWidth   = 16;
   localparam int DutyWidth    = 16;
   localparam int LuxIntWidth  = 15;
   localparam int MeasWidth    = 16;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 24;

   // Internal widths: lux in Q16.8, signed error and error sum, shared multiplier.
   localparam int LuxWidth  = 24;
   localparam int ErrWidth  = 25;
   localparam int MulAWidth = 25;
   localparam int MulBWidth = 17;
   localparam int ProdWidth = MulAWidth + MulBWidth;

   // raw / 1.2 in Q16.8 is (raw * 54613) >> 8.
   localparam logic [MulBWidth-1:0]  LUX_SCALE      = 17'd54613;
   localparam logic [CountWidth-1:0] UNDERFLOW_MARK = 16'd60000;
   localparam logic [8:0]            SMOOTH_FULL    = 9'd256;

   // Register reset values.
   localparam logic [15:0] PROP_GAIN_RST      = 16'd2867;
   localparam logic [15:0] INT_GAIN_RST       = 16'd2048;
   localparam logic [23:0] SUM_BOUND_RST      = 24'd512000;
   localparam logic [15:0] DEADBAND_RST       = 16'd51;
   localparam logic [8:0]  SMOOTHING_RST      = 9'd64;
   localparam logic [15:0] PWM_MAX_RST        = 16'd1000;
   localparam logic [14:0] SETPOINT_MAX_RST   = 15'd2000;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_PROP_GAIN      = 3'd0,
      REG_INT_GAIN       = 3'd1,
      REG_SUM_BOUND      = 3'd2,
      REG_DEADBAND       = 3'd3,
      REG_SMOOTHING      = 3'd4,
      REG_PWM_MAX        = 3'd5,
      REG_SETPOINT_MAX   = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic [15:0] prop_gain;
      logic [15:0] int_gain;
      logic [23:0] sum_bound;
      logic [15:0] deadband;
      logic [8:0]  smoothing;
      logic [15:0] pwm_max;
      logic [14:0] setpoint_max;
   } cfg_type;

   // Program steps.
   typedef enum logic [3:0] {
      STEP_SCALE = 4'd0,
      STEP_BLEND = 4'd1,
      STEP_LUX   = 4'd2,
      STEP_ERR   = 4'd3,
      STEP_TEST  = 4'd4,
      STEP_INT   = 4'd5,
      STEP_SUM   = 4'd6,
      STEP_DUTY  = 4'd7,
      STEP_OUT   = 4'd8
   } step_type;

   typedef enum logic [2:0] {
      MUL_IDLE  = 3'd0,
      MUL_SCALE = 3'd1,
      MUL_BLEND = 3'd2,
      MUL_PROP  = 3'd3,
      MUL_INT   = 3'd4
   } mul_sel_type;

   typedef enum logic [1:0] {
      JMP_NONE      = 2'd0,
      JMP_NO_SAMPLE = 2'd1,
      JMP_IN_BAND   = 2'd2
   } jump_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        lux_we;
      logic        err_we;
      logic        tot_we;
      logic        acc_load;
      logic        acc_add;
      logic        held_we;
      logic        out_we;
      jump_type    jump;
      step_type    jump_to;
      logic        last;
   } ucode_type;

   // Datapath conditions seen by the sequencer.
   typedef struct packed {
      logic smp_valid;
      logic in_band;
      logic out_free;
   } status_type;

   // Control store. A taken jump suppresses the writes of its own step.
   function automatic ucode_type ucode(step_type step);
      ucode_type w;
      w = '0;
      case (step)
         STEP_SCALE: begin
            w.mul_sel = MUL_SCALE;
            w.jump    = JMP_NO_SAMPLE;
            w.jump_to = STEP_ERR;
         end
         STEP_BLEND: w.mul_sel = MUL_BLEND;
         STEP_LUX:   w.lux_we  = 1'b1;
         STEP_ERR:   w.err_we  = 1'b1;
         STEP_TEST: begin
            w.mul_sel = MUL_PROP;
            w.tot_we  = 1'b1;
            w.jump    = JMP_IN_BAND;
            w.jump_to = STEP_OUT;
         end
         STEP_INT: begin
            w.mul_sel  = MUL_INT;
            w.acc_load = 1'b1;
         end
         STEP_SUM:   w.acc_add = 1'b1;
         STEP_DUTY:  w.held_we = 1'b1;
         STEP_OUT: begin
            w.out_we = 1'b1;
            w.last   = 1'b1;
         end
         default:    w.last = 1'b1;
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/llpr_if.sv =====
// Valid/ready channel interfaces of the light level PI regulator: request, response and
// register write. Depends on llpr_pkg for the payload widths.
interface llpr_req_if;
   logic                             valid;
   logic                             ready;
   logic                             sample_valid;
   logic [llpr_pkg::RawWidth-1:0]    sensor_raw;
   logic [llpr_pkg::CountWidth-1:0]  encoder_count;

   modport source (output valid, output sample_valid, output sensor_raw,
                   output encoder_count, input ready);
   modport sink (input valid, input sample_valid, input sensor_raw,
                 input encoder_count, output ready);
endinterface

interface llpr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [llpr_pkg::DutyWidth-1:0]    pwm_duty;
   logic [llpr_pkg::LuxIntWidth-1:0]  target_lux;
   logic [llpr_pkg::MeasWidth-1:0]    measured_lux;
   logic                              counter_rewrite;
   logic [llpr_pkg::CountWidth-1:0]   counter_value;

   modport source (output valid, output pwm_duty, output target_lux, output measured_lux,
                   output counter_rewrite, output counter_value, input ready);
   modport sink (input valid, input pwm_duty, input target_lux, input measured_lux,
                 input counter_rewrite, input counter_value, output ready);
endinterface

interface llpr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [llpr_pkg::CsrIdxWidth-1:0]   index;
   logic [llpr_pkg::CsrDataWidth-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/light_level_pi_regulator.sv =====
// Light level PI regulator, top level.
//
// One request on req_bus is one control tick: a sensor word with its valid flag and the
// encoder count. Each request gives exactly one response on rsp_bus with the PWM duty,
// the setpoint, the filtered lux value and an optional encoder counter reload.
// Registers are written on csr_bus (index 0 to 6); unknown indexes are ignored.
// csr_bus is always ready and must only be written while no request is in flight.
//
// A request runs a short microprogram on one shared 25x17 multiplier, one step a cycle
// unless the output step holds; the output step loads the response register. Without a
// valid sample the blend and lux steps are skipped; inside the deadband the program
// jumps from the test step to the output step. req_bus.ready drops while the program
// runs, so no new request is taken before it ends. A waiting response does not block the
// next request; only the output step holds until the previous response has been taken.
//
// Reset restores the register defaults, clears the lux estimate, the error sum and the
// held duty, and leaves no response pending.
module light_level_pi_regulator (
   input  logic          clock,
   input  logic          reset,
   llpr_req_if.sink      req_bus,
   llpr_rsp_if.source    rsp_bus,
   llpr_csr_if.sink      csr_bus
);

   llpr_pkg::cfg_type    cfg_ff;
   llpr_pkg::ucode_type  ctrl;
   llpr_pkg::status_type status;
   logic                 busy;
   logic                 start;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !busy;
   assign start         = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain      <= llpr_pkg::PROP_GAIN_RST;
         cfg_ff.int_gain       <= llpr_pkg::INT_GAIN_RST;
         cfg_ff.sum_bound      <= llpr_pkg::SUM_BOUND_RST;
         cfg_ff.deadband       <= llpr_pkg::DEADBAND_RST;
         cfg_ff.smoothing      <= llpr_pkg::SMOOTHING_RST;
         cfg_ff.pwm_max        <= llpr_pkg::PWM_MAX_RST;
         cfg_ff.setpoint_max   <= llpr_pkg::SETPOINT_MAX_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            llpr_pkg::REG_PROP_GAIN:      cfg_ff.prop_gain      <= csr_bus.data[15:0];
            llpr_pkg::REG_INT_GAIN:       cfg_ff.int_gain       <= csr_bus.data[15:0];
            llpr_pkg::REG_SUM_BOUND:      cfg_ff.sum_bound      <= csr_bus.data[23:0];
            llpr_pkg::REG_DEADBAND:       cfg_ff.deadband       <= csr_bus.data[15:0];
            llpr_pkg::REG_SMOOTHING:      cfg_ff.smoothing      <= csr_bus.data[8:0];
            llpr_pkg::REG_PWM_MAX:        cfg_ff.pwm_max        <= csr_bus.data[15:0];
            llpr_pkg::REG_SETPOINT_MAX:   cfg_ff.setpoint_max   <= csr_bus.data[14:0];
            default: ;
         endcase
      end
   end

   llpr_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   llpr_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_sample_valid    (req_bus.sample_valid),
      .req_sensor_raw      (req_bus.sensor_raw),
      .req_encoder_count   (req_bus.encoder_count),
      .cfg                 (cfg_ff),
      .ctrl                (ctrl),
      .status              (status),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_pwm_duty        (rsp_bus.pwm_duty),
      .rsp_target_lux      (rsp_bus.target_lux),
      .rsp_measured_lux    (rsp_bus.measured_lux),
      .rsp_counter_rewrite (rsp_bus.counter_rewrite),
      .rsp_counter_value   (rsp_bus.counter_value)
   );

endmodule

// ===== hw/rtl/llpr_sequencer.sv =====
// Step counter of the regulator: reads the control store, resolves conditional jumps
// and holds on the output step while the response register is occupied. Uses llpr_pkg.
module llpr_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  llpr_pkg::status_type status,
   output llpr_pkg::ucode_type  ctrl,
   output logic                 busy
);

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   seq_state_type       state_ff, state_in;
   llpr_pkg::step_type  step_ff, step_in;
   llpr_pkg::ucode_type word;
   logic                taken;
   logic                stall;

   always_comb begin
      word  = llpr_pkg::ucode(step_ff);
      taken = ((word.jump == llpr_pkg::JMP_NO_SAMPLE) && !status.smp_valid) ||
              ((word.jump == llpr_pkg::JMP_IN_BAND) && status.in_band);
      stall = word.out_we && !status.out_free;

      ctrl = word;
      if ((state_ff != SEQ_RUN) || taken || stall) begin
         ctrl = '0;
      end

      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               step_in  = llpr_pkg::STEP_SCALE;
            end
         end
         SEQ_RUN: begin
            if (taken) begin
               step_in = word.jump_to;
            end else if (stall) begin
               step_in = step_ff;
            end else if (word.last) begin
               state_in = SEQ_IDLE;
            end else begin
               step_in = llpr_pkg::step_type'(step_ff + 4'd1);
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= llpr_pkg::STEP_SCALE;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign busy = (state_ff == SEQ_RUN);

   // A new request is only taken when the program is not running.
   assert property (@(posedge clock) disable iff (reset) start |-> !busy)
      else $error("request started while the program was running");

   // The output step never overwrites a response that is still waiting.
   assert property (@(posedge clock) disable iff (reset) ctrl.out_we |-> status.out_free)
      else $error("response register written while occupied");

   // A taken jump leaves the program running.
   assert property (@(posedge clock) disable iff (reset) (busy && taken) |=> busy)
      else $error("program stopped on a jump");

endmodule

// ===== hw/rtl/llpr_datapath.sv =====
// Datapath of the regulator: one shared signed multiplier, product and sum registers,
// the filter and controller state, and the response register. Uses llpr_pkg.
module llpr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                req_sample_valid,
   input  logic [llpr_pkg::RawWidth-1:0]       req_sensor_raw,
   input  logic [llpr_pkg::CountWidth-1:0]     req_encoder_count,
   input  llpr_pkg::cfg_type                   cfg,
   input  llpr_pkg::ucode_type                 ctrl,
   output llpr_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [llpr_pkg::DutyWidth-1:0]      rsp_pwm_duty,
   output logic [llpr_pkg::LuxIntWidth-1:0]    rsp_target_lux,
   output logic [llpr_pkg::MeasWidth-1:0]      rsp_measured_lux,
   output logic                                rsp_counter_rewrite,
   output logic [llpr_pkg::CountWidth-1:0]     rsp_counter_value
);

   // Captured request.
   logic                                smp_valid_ff;
   logic [llpr_pkg::RawWidth-1:0]       raw_ff;
   logic [llpr_pkg::CountWidth-1:0]     count_ff;

   // Working registers and state.
   logic signed [llpr_pkg::ProdWidth-1:0] prod_ff, prod_in;
   logic signed [llpr_pkg::ProdWidth-1:0] acc_ff, acc_in;
   logic signed [llpr_pkg::ErrWidth-1:0]  err_ff, err_in;
   logic signed [llpr_pkg::ErrWidth-1:0]  tot_ff, tot_in;
   logic [llpr_pkg::LuxWidth-1:0]         lux_ff, lux_in;
   logic [llpr_pkg::DutyWidth-1:0]        held_ff, held_in;

   // Response register.
   logic                                  rsp_valid_ff;
   logic [llpr_pkg::DutyWidth-1:0]        duty_out_ff;
   logic [llpr_pkg::LuxIntWidth-1:0]      target_out_ff;
   logic [llpr_pkg::MeasWidth-1:0]        meas_out_ff;
   logic                                  rewrite_out_ff;
   logic [llpr_pkg::CountWidth-1:0]       value_out_ff;

   logic [llpr_pkg::LuxIntWidth-1:0]      setpoint;
   logic                                  rewrite;
   logic [llpr_pkg::CountWidth-1:0]       reload;
   logic [8:0]                            smooth;
   logic signed [llpr_pkg::ErrWidth-1:0]  diff;
   logic signed [llpr_pkg::MulAWidth-1:0] mul_a;
   logic signed [llpr_pkg::MulBWidth-1:0] mul_b;
   logic signed [llpr_pkg::ProdWidth-1:0] prod_sh;
   logic signed [33:0]                    lux_sum;
   logic [llpr_pkg::ErrWidth-1:0]         err_mag;
   logic signed [llpr_pkg::ErrWidth:0]    tsum;
   logic signed [llpr_pkg::ErrWidth:0]    lim_pos;
   logic signed [llpr_pkg::ErrWidth:0]    lim_neg;
   logic signed [llpr_pkg::ErrWidth:0]    tot_clamp;
   logic [21:0]                           duty_q;
   logic                                  out_free;

   // Setpoint from the encoder count, with the reload request of each clamp.
   always_comb begin
      setpoint = count_ff[15:1];
      rewrite  = 1'b0;
      reload   = '0;
      if (count_ff > llpr_pkg::UNDERFLOW_MARK) begin
         setpoint = '0;
         rewrite  = 1'b1;
      end else if (count_ff[15:1] > cfg.setpoint_max) begin
         setpoint = cfg.setpoint_max;
         rewrite  = 1'b1;
         reload   = {cfg.setpoint_max, 1'b0};
      end
   end

   always_comb begin
      smooth = (cfg.smoothing > llpr_pkg::SMOOTH_FULL) ? llpr_pkg::SMOOTH_FULL : cfg.smoothing;
      // After the scale step the product holds the new sample in Q16.8 above bit 8.
      diff   = $signed({1'b0, prod_ff[31:8]}) - $signed({1'b0, lux_ff});

      case (ctrl.mul_sel)
         llpr_pkg::MUL_SCALE: begin
            mul_a = $signed({9'd0, raw_ff});
            mul_b = $signed(llpr_pkg::LUX_SCALE);
         end
         llpr_pkg::MUL_BLEND: begin
            mul_a = diff;
            mul_b = $signed({8'd0, smooth});
         end
         llpr_pkg::MUL_PROP: begin
            mul_a = err_ff;
            mul_b = $signed({1'b0, cfg.prop_gain});
         end
         llpr_pkg::MUL_INT: begin
            mul_a = tot_ff;
            mul_b = $signed({1'b0, cfg.int_gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;

      // The blend s*m + (256-s)*lux is written as 256*lux + s*(m - lux).
      prod_sh = prod_ff >>> 8;
      lux_sum = $signed({10'd0, lux_ff}) + $signed(prod_sh[33:0]);
      lux_in  = lux_sum[llpr_pkg::LuxWidth-1:0];

      err_in  = $signed({2'b00, setpoint, 8'd0}) - $signed({1'b0, lux_ff});
      err_mag = err_ff[llpr_pkg::ErrWidth-1] ? llpr_pkg::ErrWidth'(-err_ff)
                                             : llpr_pkg::ErrWidth'(err_ff);

      tsum    = $signed({tot_ff[llpr_pkg::ErrWidth-1], tot_ff}) +
                $signed({err_ff[llpr_pkg::ErrWidth-1], err_ff});
      lim_pos = $signed({2'b00, cfg.sum_bound});
      lim_neg = -lim_pos;
      if (tsum > lim_pos) begin
         tot_clamp = lim_pos;
      end else if (tsum < lim_neg) begin
         tot_clamp = lim_neg;
      end else begin
         tot_clamp = tsum;
      end
      tot_in = tot_clamp[llpr_pkg::ErrWidth-1:0];

      acc_in = ctrl.acc_add ? (acc_ff + prod_ff) : prod_ff;

      // Output in Q.20 truncated toward zero; a non-positive drive gives zero duty.
      duty_q = acc_ff[41:20];
      if (acc_ff <= 42'sd0) begin
         held_in = '0;
      end else if (duty_q > {6'd0, cfg.pwm_max}) begin
         held_in = cfg.pwm_max;
      end else begin
         held_in = duty_q[llpr_pkg::DutyWidth-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (start) begin
         smp_valid_ff <= req_sample_valid;
         raw_ff       <= req_sensor_raw;
         count_ff     <= req_encoder_count;
      end
      if (ctrl.mul_sel != llpr_pkg::MUL_IDLE) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_load || ctrl.acc_add) begin
         acc_ff <= acc_in;
      end
      if (ctrl.err_we) begin
         err_ff <= err_in;
      end
      if (ctrl.out_we) begin
         duty_out_ff    <= held_ff;
         target_out_ff  <= setpoint;
         meas_out_ff    <= lux_ff[23:8];
         rewrite_out_ff <= rewrite;
         value_out_ff   <= reload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lux_ff       <= '0;
         tot_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.lux_we) begin
            lux_ff <= lux_in;
         end
         if (ctrl.tot_we) begin
            tot_ff <= tot_in;
         end
         if (ctrl.held_we) begin
            held_ff <= held_in;
         end
         if (ctrl.out_we) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.smp_valid = smp_valid_ff;
   assign status.in_band   = err_mag < {9'd0, cfg.deadband};
   assign status.out_free  = out_free;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pwm_duty        = duty_out_ff;
   assign rsp_target_lux      = target_out_ff;
   assign rsp_measured_lux    = meas_out_ff;
   assign rsp_counter_rewrite = rewrite_out_ff;
   assign rsp_counter_value   = value_out_ff;

   // The stored duty never exceeds the limit that was in force when it was computed.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.held_we |=> (held_ff <= $past(cfg.pwm_max)))
      else $error("held duty above the PWM limit");

   // A response only appears through the output step of the program.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.out_we))
      else $error("response raised without an output step");

   // A reload value is only reported together with a reload request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rewrite_out_ff) |-> (value_out_ff == '0))
      else $error("reload value without a reload request");

endmodule

// ===== test/tb_light_level_pi_regulator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the light level PI regulator: random and directed control ticks
// checked against a predictor of the filter, setpoint clamp and PI law kept in this file.
// Depends on llpr_pkg, the channel interfaces in llpr_if.sv and light_level_pi_regulator.
module tb_light_level_pi_regulator;

   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned PHASE_TICKS   = 231;
   localparam int unsigned PHASE_COUNT   = 8;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned STALL_CYCLES  = 400;
   localparam int unsigned IDLE_PERCENT  = 36;

   localparam longint unsigned LUX_PER_RAW     = 54613;
   localparam int unsigned     COUNT_UNDERFLOW = 60000;
   localparam logic [2:0]      REG_UNMAPPED    = 3'd7;

   localparam llpr_pkg::cfg_type DEFAULT_SETTING =
      '{16'd2867, 16'd2048, 24'd512000, 16'd51, 9'd64, 16'd1000, 15'd2000};

   typedef struct packed {
      logic        sample_valid;
      logic [15:0] sensor_raw;
      logic [15:0] encoder_count;
   } tick_type;

   typedef struct packed {
      logic [15:0] pwm_duty;
      logic [14:0] target_lux;
      logic [15:0] measured_lux;
      logic        counter_rewrite;
      logic [15:0] counter_value;
   } reading_type;

   logic clock = 1'b0;
   logic reset;

   llpr_req_if req_chan ();
   llpr_rsp_if rsp_chan ();
   llpr_csr_if csr_chan ();

   light_level_pi_regulator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_chan),
      .rsp_bus (rsp_chan),
      .csr_bus (csr_chan)
   );

   // Predictor state: registers, filtered lux (Q16.8), error sum and the duty being held.
   llpr_pkg::cfg_type cfg;
   logic [23:0] lux_q;
   int          err_sum;
   logic [15:0] held;

   tick_type    tick_q[$];
   reading_type reading_q[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left;
   bit          stall_taken;
   bit          stall_armed = 1'b0;
   bit          calm = 1'b0;
   bit          hold_send = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic reading_type regulate_tick(tick_type t);
      reading_type     r;
      longint unsigned scaled, weight, blend, duty;
      longint          err, mag, band, limit, total, drive, sp_fixed, lux_fixed;
      logic [14:0]     setpt;
      r = '0;
      if (t.sample_valid) begin
         scaled = (longint'(t.sensor_raw) * LUX_PER_RAW) >> 8;
         weight = (cfg.smoothing > 9'd256) ? 256 : cfg.smoothing;
         blend  = (weight * scaled + (256 - weight) * longint'(lux_q)) >> 8;
         lux_q  = blend[23:0];
      end
      if (t.encoder_count > COUNT_UNDERFLOW) begin
         setpt = '0;
         r.counter_rewrite = 1'b1;
      end else if (t.encoder_count[15:1] > cfg.setpoint_max) begin
         setpt = cfg.setpoint_max;
         r.counter_rewrite = 1'b1;
         r.counter_value = {cfg.setpoint_max, 1'b0};
      end else begin
         setpt = t.encoder_count[15:1];
      end
      sp_fixed  = setpt;
      lux_fixed = lux_q;
      err  = (sp_fixed << 8) - lux_fixed;
      mag  = (err < 0) ? -err : err;
      band = cfg.deadband;
      if (mag >= band) begin
         limit = cfg.sum_bound;
         total = longint'(err_sum) + err;
         if (total > limit) total = limit;
         if (total < -limit) total = -limit;
         err_sum = int'(total);
         drive = longint'(cfg.prop_gain) * err + longint'(cfg.int_gain) * total;
         duty = (drive <= 0) ? 0 : longint'(drive >> 20);
         if (duty > cfg.pwm_max) duty = cfg.pwm_max;
         held = duty[15:0];
      end
      r.pwm_duty     = held;
      r.target_lux   = setpt;
      r.measured_lux = lux_q[23:8];
      return r;
   endfunction

   function automatic void store_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
         llpr_pkg::REG_PROP_GAIN:    cfg.prop_gain    = data[15:0];
         llpr_pkg::REG_INT_GAIN:     cfg.int_gain     = data[15:0];
         llpr_pkg::REG_SUM_BOUND:    cfg.sum_bound    = data;
         llpr_pkg::REG_DEADBAND:     cfg.deadband     = data[15:0];
         llpr_pkg::REG_SMOOTHING:    cfg.smoothing    = data[8:0];
         llpr_pkg::REG_PWM_MAX:      cfg.pwm_max      = data[15:0];
         llpr_pkg::REG_SETPOINT_MAX: cfg.setpoint_max = data[14:0];
         default: ;
      endcase
   endfunction

   // Picks zero, all ones, the reset value or a random value for one register field.
   function automatic logic [23:0] choose(int unsigned bits, logic [23:0] dflt);
      logic [23:0] top;
      top = 24'((32'd1 << bits) - 1);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return top;
         2, 3:    return dflt;
         default: return 24'($urandom()) & top;
      endcase
   endfunction

   function automatic llpr_pkg::cfg_type pick_setting(int unsigned kind);
      llpr_pkg::cfg_type s;
      case (kind)
         0: s = '0;
         1: s = '1;
         default: begin
            s.prop_gain    = 16'(choose(16, 24'(DEFAULT_SETTING.prop_gain)));
            s.int_gain     = 16'(choose(16, 24'(DEFAULT_SETTING.int_gain)));
            s.sum_bound    = choose(24, DEFAULT_SETTING.sum_bound);
            s.deadband     = 16'(choose(16, 24'(DEFAULT_SETTING.deadband)));
            s.smoothing    = 9'(choose(9, 24'(DEFAULT_SETTING.smoothing)));
            s.pwm_max      = 16'(choose(16, 24'(DEFAULT_SETTING.pwm_max)));
            s.setpoint_max = 15'(choose(15, 24'(DEFAULT_SETTING.setpoint_max)));
         end
      endcase
      return s;
   endfunction

   // Call just after a rising edge; leaves valid high for the caller to lower.
   task automatic put_reg(logic [2:0] idx, logic [23:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      store_reg(idx, data);
   endtask

   // Upper data bits beyond each field are filled with noise, which the block must drop.
   task automatic apply_setting(llpr_pkg::cfg_type s);
      logic [23:0] d;
      @(posedge clock);
      d = 24'($urandom()); d[15:0] = s.prop_gain;    put_reg(llpr_pkg::REG_PROP_GAIN, d);
      d = 24'($urandom()); d[15:0] = s.int_gain;     put_reg(llpr_pkg::REG_INT_GAIN, d);
      d = s.sum_bound;                               put_reg(llpr_pkg::REG_SUM_BOUND, d);
      d = 24'($urandom()); d[15:0] = s.deadband;     put_reg(llpr_pkg::REG_DEADBAND, d);
      d = 24'($urandom()); d[8:0]  = s.smoothing;    put_reg(llpr_pkg::REG_SMOOTHING, d);
      d = 24'($urandom()); d[15:0] = s.pwm_max;      put_reg(llpr_pkg::REG_PWM_MAX, d);
      d = 24'($urandom()); d[14:0] = s.setpoint_max; put_reg(llpr_pkg::REG_SETPOINT_MAX, d);
      d = 24'($urandom());                           put_reg(REG_UNMAPPED, d);
      csr_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_chan.valid || reading_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_tick(logic v, int unsigned raw, int unsigned count);
      tick_q.push_back('{v, 16'(raw), 16'(count)});
   endtask

   // Mostly runs of ticks whose light reading sits near the setpoint, so the filter settles
   // and the deadband is reached; the rest is unrelated noise with edge counts.
   task automatic queue_random(int unsigned amount);
      int unsigned     left, run, aim, level, raw, count;
      longint unsigned ideal;
      left = amount;
      while (left != 0) begin
         if ($urandom_range(0, 99) < 70) begin
            aim = $urandom_range(0, 2 * cfg.setpoint_max + 3);
            if (aim > 65535) aim = 65535;
            if (aim > COUNT_UNDERFLOW) level = 0;
            else if ((aim >> 1) > cfg.setpoint_max) level = cfg.setpoint_max;
            else level = aim >> 1;
            ideal = (longint'(level) * 65536 + LUX_PER_RAW / 2) / LUX_PER_RAW;
            run = $urandom_range(1, 12);
            if (run > left) run = left;
            repeat (run) begin
               raw = int'(ideal) + $urandom_range(0, 6);
               raw = (raw > 3) ? raw - 3 : 0;
               if (raw > 65535) raw = 65535;
               queue_tick($urandom_range(0, 9) != 0, raw, aim);
            end
            left -= run;
         end else begin
            case ($urandom_range(0, 3))
               0:       count = $urandom_range(59990, 60010);
               1:       count = $urandom_range(65520, 65535);
               2:       count = $urandom_range(0, 15);
               default: count = $urandom_range(0, 65535);
            endcase
            queue_tick(1'($urandom_range(0, 1)), $urandom_range(0, 65535), count);
            left--;
         end
      end
   endtask

   // Request driver: the prediction is made at the edge that accepts the request.
   always @(posedge clock) begin
      tick_type next_tick;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            reading_q.push_back(regulate_tick('{req_chan.sample_valid, req_chan.sensor_raw,
                                                req_chan.encoder_count}));
         if (!req_chan.valid || req_chan.ready) begin
            if (tick_q.size() != 0 && !hold_send &&
                (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               next_tick = tick_q.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.sample_valid  <= next_tick.sample_valid;
               req_chan.sensor_raw    <= next_tick.sensor_raw;
               req_chan.encoder_count <= next_tick.encoder_count;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, taken once when armed.
   always @(posedge clock) begin
      if (reset) begin
         stall_left  <= 0;
         stall_taken <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (stall_armed && !stall_taken) begin
         stall_left  <= STALL_CYCLES;
         stall_taken <= 1'b1;
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      reading_type seen, want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = '{rsp_chan.pwm_duty, rsp_chan.target_lux, rsp_chan.measured_lux,
                     rsp_chan.counter_rewrite, rsp_chan.counter_value};
            if (reading_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected response: duty %0d target %0d lux %0d reload %0b/%0d",
                           seen.pwm_duty, seen.target_lux, seen.measured_lux,
                           seen.counter_rewrite, seen.counter_value);
            end else begin
               want = reading_q.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("mismatch: expected duty %0d target %0d lux %0d reload %0b/%0d",
                              want.pwm_duty, want.target_lux, want.measured_lux,
                              want.counter_rewrite, want.counter_value);
                     $display("          actual   duty %0d target %0d lux %0d reload %0b/%0d",
                              seen.pwm_duty, seen.target_lux, seen.measured_lux,
                              seen.counter_rewrite, seen.counter_value);
                  end
               end
            end
         end
         rsp_chan.ready <= (stall_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int unsigned phase;
      cfg     = DEFAULT_SETTING;
      lux_q   = '0;
      err_sum = 0;
      held    = '0;
      reset   = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.sample_valid  = 1'b0;
      req_chan.sensor_raw    = '0;
      req_chan.encoder_count = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: field extremes, setpoint clamp, underflow and a dropped sample.
      queue_tick(1'b1, 0, 0);
      queue_tick(1'b1, 65535, 4000);
      queue_tick(1'b0, 65535, 4001);
      queue_tick(1'b1, 65535, 60000);
      queue_tick(1'b1, 0, 60001);
      queue_tick(1'b0, 12345, 65535);
      queue_tick(1'b1, 0, 3000);
      queue_tick(1'b1, 40000, 0);
      queue_tick(1'b0, 0, 1);
      drain();

      // Smoothing above full scale; a reading exactly inside the deadband, then wind-up.
      apply_setting('{16'd4096, 16'd4096, 24'd512000, 16'd51, 9'd300, 16'd1000, 15'd2000});
      queue_tick(1'b1, 1200, 2000);
      repeat (3) queue_tick(1'b1, 0, 4000);
      drain();

      // Limit lowered below the wound-up sum: held inside the band, clamped at the next update.
      apply_setting('{16'd4096, 16'd4096, 24'd1000, 16'd51, 9'd300, 16'd65535, 15'd2000});
      queue_tick(1'b1, 1200, 2000);
      queue_tick(1'b1, 1250, 2000);
      queue_tick(1'b1, 0, 6000);
      queue_tick(1'b1, 65535, 0);
      drain();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         apply_setting(pick_setting(phase));
         calm        = (phase == 2);
         stall_armed = (phase == 2);
         queue_random(PHASE_TICKS);
         if (phase == 4) begin
            do @(negedge clock); while (tick_q.size() > PHASE_TICKS / 2);
            hold_send = 1'b1;
            do @(negedge clock); while (req_chan.valid || reading_q.size() != 0);
            hold_send = 1'b0;
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
